// ===== rtl/lsa_pkg.sv =====
package lsa_pkg;

  localparam int DAY_W = 16;
  localparam int OFF_W = 13;
  localparam int IDX_W = 11;
  localparam int CNT_W = 11;
  localparam int NEED_W = 13;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int RET_W = 16;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;
  localparam logic [RET_W-1:0] RET_RESET = 16'd7;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_LOAD   = 3'd1,
    OP_START  = 3'd2,
    OP_MARK   = 3'd3,
    OP_GC     = 3'd4,
    OP_QUAR   = 3'd5,
    OP_STATUS = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SECTOR = 2'd1,
    STAT_BLOCKED   = 2'd2,
    STAT_FULL      = 2'd3
  } stat_e;

  typedef enum logic {
    REG_MAX_DAILY = 1'b0,
    REG_RETENTION = 1'b1
  } reg_e;

  typedef struct packed {
    logic             present;
    logic             pushed;
    logic             blank;
    logic             bad;
    logic [DAY_W-1:0] day;
    logic [OFF_W-1:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/log_sector_allocator.sv =====
// Load, quarantine and status items, and appends that need no scan, complete without a table scan.
// Table scans (roll forward, select, hint, create, mark pushed, gc) read one entry per
// cycle from the single-read-port table.
// One item at a time; the next item is taken as soon as the result sits in the output register.
// Reset: control state clears at once, then a pass writes every table entry to zero,
// while no item is accepted (register writes are taken).
module log_sector_allocator #(
  parameter int NUM_SECTORS  = 2048,
  parameter int SECTOR_BYTES = 4096,
  parameter int HEADER_BYTES = 12,
  parameter int BAD_LIST_MAX = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsa_pkg::APB_AW-1:0]   paddr,
  input  logic [lsa_pkg::APB_DW-1:0]   pwdata,
  output logic [lsa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   opcode_i,
  input  logic [lsa_pkg::IDX_W-1:0]    sector_index_i,
  input  logic [lsa_pkg::DAY_W-1:0]    day_id_i,
  input  logic [lsa_pkg::NEED_W-1:0]   need_bytes_i,
  input  logic                         entry_present_i,
  input  logic                         entry_pushed_i,
  input  logic                         entry_blank_i,
  input  logic [lsa_pkg::OFF_W-1:0]    entry_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [lsa_pkg::IDX_W-1:0]    current_sector_out_o,
  output logic [lsa_pkg::OFF_W-1:0]    record_offset_o,
  output logic                         low_space_flag_o,
  output logic [lsa_pkg::CNT_W-1:0]    affected_count_o
);

  import lsa_pkg::*;

  localparam int AW = $clog2(NUM_SECTORS);
  localparam int RES = NUM_SECTORS - 1;
  localparam int BW = $clog2(BAD_LIST_MAX + 1);
  localparam logic [AW-1:0] RES_A = AW'(RES);
  localparam logic [AW-1:0] LAST_A = AW'(RES - 1);
  localparam logic [AW-1:0] CLR_END = AW'(NUM_SECTORS - 1);
  localparam logic [AW:0] RES_N = (AW + 1)'(RES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROLL, S_SEL, S_HINT, S_CREATE, S_SWEEP,
    S_RD1, S_RMW, S_ACHK, S_AOFF, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0] op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [DAY_W-1:0] din_q, din_d;
  logic [NEED_W-1:0] need_q, need_d;
  entry_t ld_q, ld_d;
  logic [31:0] max_q;
  logic [RET_W-1:0] ret_q;
  logic [AW-1:0] cur_q, cur_d;
  logic cur_v_q, cur_v_d;
  logic [DAY_W-1:0] day_q, day_d;
  logic [31:0] bytes_q, bytes_d;
  logic blk_q, blk_d;
  logic [AW-1:0] hint_q, hint_d;
  logic [BW-1:0] bad_q, bad_d;
  logic [AW-1:0] scan_a_q, scan_a_d;
  logic [AW:0] left_q, left_d;
  logic pend_q, pend_d;
  logic [AW-1:0] pend_a_q, pend_a_d;
  logic dn_q, dn_d;
  logic full_ctx_q, full_ctx_d;
  logic force_q, force_d;
  logic [AW-1:0] cnt_q, cnt_d;
  stat_e res_stat_q, res_stat_d;
  logic [OFF_W-1:0] rec_q, rec_d;
  logic out_v_q, out_v_d;
  logic [1:0] o_stat_q, o_stat_d;
  logic [IDX_W-1:0] o_cur_q, o_cur_d;
  logic [OFF_W-1:0] o_rec_q, o_rec_d;
  logic o_blk_q, o_blk_d;
  logic [CNT_W-1:0] o_cnt_q, o_cnt_d;

  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t mem_wd, rd;
  logic [ENTRY_W-1:0] mem_rdata;

  logic cond, stop, issue, scan_end;
  logic [AW-1:0] next_a;
  logic [32:0] bsum;
  logic [OFF_W:0] osum;
  logic [DAY_W-1:0] age;
  logic accept;
  entry_t claim;
  stat_e misc_stat;

  lsa_ram #(.Width(ENTRY_W), .Depth(NUM_SECTORS)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rdata)
  );

  assign rd = entry_t'(mem_rdata);
  assign pready = 1'b1;
  assign prdata = (reg_e'(paddr[2]) == REG_RETENTION) ? {16'd0, ret_q} : max_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign bsum = {1'b0, bytes_q} + 33'(need_q);
  assign osum = {1'b0, rd.offset} + (OFF_W + 1)'(need_q);
  assign age = din_q - rd.day;
  assign misc_stat = cur_v_q ? STAT_OK : STAT_NO_SECTOR;
  assign next_a = dn_q ? scan_a_q - 1'b1 : ((scan_a_q == LAST_A) ? '0 : scan_a_q + 1'b1);
  assign scan_end = !pend_q && (left_q == '0);

  always_comb begin
    claim = '0;
    claim.present = 1'b1;
    claim.day = day_q;
    claim.offset = OFF_W'(HEADER_BYTES);
  end

  always_comb begin
    case (state_q)
      S_ROLL, S_CREATE: cond = !rd.bad && rd.blank;
      S_SEL:            cond = rd.present && (rd.day == day_q) && !rd.bad;
      S_HINT:           cond = !rd.bad;
      S_SWEEP: begin
        if (op_e'(op_q) == OP_MARK) begin
          cond = rd.present && (rd.day == din_q);
        end else begin
          cond = rd.present && rd.pushed && (din_q >= rd.day) && (age >= ret_q);
        end
      end
      default:          cond = 1'b0;
    endcase
  end

  assign stop = pend_q && cond && (state_q != S_SWEEP);
  assign issue = !stop && (left_q != '0);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    op_d = op_q;
    idx_d = idx_q;
    din_d = din_q;
    need_d = need_q;
    ld_d = ld_q;
    cur_d = cur_q;
    cur_v_d = cur_v_q;
    day_d = day_q;
    bytes_d = bytes_q;
    blk_d = blk_q;
    hint_d = hint_q;
    bad_d = bad_q;
    scan_a_d = scan_a_q;
    left_d = left_q;
    pend_d = 1'b0;
    pend_a_d = pend_a_q;
    dn_d = dn_q;
    full_ctx_d = full_ctx_q;
    force_d = force_q;
    cnt_d = cnt_q;
    res_stat_d = res_stat_q;
    rec_d = rec_q;
    out_v_d = out_v_q && !out_ready_i;
    o_stat_d = o_stat_q;
    o_cur_d = o_cur_q;
    o_rec_d = o_rec_q;
    o_blk_d = o_blk_q;
    o_cnt_d = o_cnt_q;
    mem_we = 1'b0;
    mem_wa = pend_a_q;
    mem_wd = claim;
    mem_ra = scan_a_q;

    if (state_q inside {S_ROLL, S_SEL, S_HINT, S_CREATE, S_SWEEP} && issue) begin
      pend_d = 1'b1;
      pend_a_d = scan_a_q;
      scan_a_d = next_a;
      left_d = left_q - 1'b1;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_END) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d = opcode_i;
          idx_d = sector_index_i;
          din_d = day_id_i;
          need_d = need_bytes_i;
          ld_d.present = entry_present_i;
          ld_d.pushed = entry_pushed_i;
          ld_d.blank = entry_blank_i;
          ld_d.bad = 1'b0;
          ld_d.day = day_id_i;
          ld_d.offset = entry_offset_i;
          cnt_d = '0;
          rec_d = '0;
          force_d = 1'b0;
          full_ctx_d = 1'b0;
          res_stat_d = misc_stat;
          case (op_e'(opcode_i))
            OP_APPEND: begin
              if (!cur_v_q) begin
                res_stat_d = STAT_NO_SECTOR;
                state_d = S_DONE;
              end else if (day_id_i != day_q) begin
                day_d = day_id_i;
                bytes_d = '0;
                blk_d = 1'b0;
                scan_a_d = cur_q + 1'b1;
                left_d = RES_N - 1'b1 - (AW + 1)'(cur_q);
                dn_d = 1'b0;
                state_d = S_ROLL;
              end else begin
                state_d = S_ACHK;
              end
            end
            OP_START: begin
              day_d = day_id_i;
              scan_a_d = LAST_A;
              left_d = RES_N;
              dn_d = 1'b1;
              state_d = S_SEL;
            end
            OP_LOAD: begin
              state_d = (32'(sector_index_i) < 32'(RES)) ? S_RD1 : S_DONE;
            end
            OP_MARK, OP_GC: begin
              scan_a_d = '0;
              left_d = RES_N;
              dn_d = 1'b0;
              state_d = S_SWEEP;
            end
            OP_QUAR: begin
              if (sector_index_i != '0 && 32'(sector_index_i) < 32'(RES) &&
                  32'(bad_q) < 32'(BAD_LIST_MAX)) begin
                state_d = S_RD1;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ROLL: begin
        if (stop) begin
          mem_we = 1'b1;
          cur_d = pend_a_q;
          cur_v_d = 1'b1;
          force_d = full_ctx_q;
          state_d = S_ACHK;
        end else if (scan_end) begin
          if (full_ctx_q) begin
            res_stat_d = STAT_FULL;
            state_d = S_DONE;
          end else begin
            scan_a_d = LAST_A;
            left_d = RES_N;
            dn_d = 1'b1;
            state_d = S_SEL;
          end
        end
      end
      S_SEL: begin
        if (stop) begin
          cur_d = pend_a_q;
          cur_v_d = 1'b1;
          if (op_e'(op_q) == OP_APPEND) begin
            state_d = S_ACHK;
          end else begin
            bytes_d = '0;
            blk_d = 1'b0;
            res_stat_d = STAT_OK;
            state_d = S_DONE;
          end
        end else if (scan_end) begin
          scan_a_d = hint_q;
          left_d = RES_N;
          dn_d = 1'b0;
          state_d = S_HINT;
        end
      end
      S_HINT: begin
        if (stop) begin
          hint_d = (pend_a_q == LAST_A) ? '0 : pend_a_q + 1'b1;
          scan_a_d = pend_a_q;
          left_d = RES_N;
          state_d = S_CREATE;
        end else if (scan_end) begin
          scan_a_d = '0;
          left_d = RES_N;
          state_d = S_CREATE;
        end
      end
      S_CREATE: begin
        if (stop) begin
          mem_we = 1'b1;
          cur_d = pend_a_q;
          cur_v_d = 1'b1;
          if (op_e'(op_q) == OP_APPEND) begin
            state_d = S_ACHK;
          end else begin
            bytes_d = '0;
            blk_d = 1'b0;
            res_stat_d = STAT_OK;
            state_d = S_DONE;
          end
        end else if (scan_end) begin
          cur_d = '0;
          cur_v_d = 1'b0;
          res_stat_d = STAT_FULL;
          state_d = S_DONE;
        end
      end
      S_SWEEP: begin
        if (pend_q && cond) begin
          mem_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (op_e'(op_q) == OP_MARK) begin
            mem_wd = rd;
            mem_wd.pushed = 1'b1;
          end else begin
            mem_wd = '0;
            mem_wd.blank = 1'b1;
            mem_wd.bad = rd.bad;
          end
        end
        if (scan_end) begin
          res_stat_d = misc_stat;
          state_d = S_DONE;
        end
      end
      S_RD1: begin
        mem_ra = AW'(idx_q);
        state_d = S_RMW;
      end
      S_RMW: begin
        mem_wa = AW'(idx_q);
        if (op_e'(op_q) == OP_LOAD) begin
          mem_we = 1'b1;
          mem_wd = ld_q;
          mem_wd.day = din_q;
          mem_wd.bad = rd.bad;
        end else if (!rd.bad) begin
          mem_we = 1'b1;
          mem_wd = rd;
          mem_wd.bad = 1'b1;
          bad_d = bad_q + 1'b1;
        end
        res_stat_d = misc_stat;
        state_d = S_DONE;
      end
      S_ACHK: begin
        if (max_q != '0 && bsum > {1'b0, max_q}) begin
          blk_d = 1'b1;
          res_stat_d = STAT_BLOCKED;
          state_d = S_DONE;
        end else begin
          mem_ra = cur_q;
          state_d = S_AOFF;
        end
      end
      S_AOFF: begin
        if (!force_q && 32'(osum) > 32'(SECTOR_BYTES)) begin
          full_ctx_d = 1'b1;
          scan_a_d = cur_q + 1'b1;
          left_d = RES_N - 1'b1 - (AW + 1)'(cur_q);
          dn_d = 1'b0;
          state_d = S_ROLL;
        end else begin
          rec_d = rd.offset;
          mem_we = 1'b1;
          mem_wa = cur_q;
          mem_wd = rd;
          mem_wd.offset = osum[OFF_W] ? OFF_MAX : osum[OFF_W-1:0];
          bytes_d = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
          res_stat_d = STAT_OK;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          o_stat_d = res_stat_q;
          o_cur_d = cur_v_q ? IDX_W'(cur_q) : '0;
          o_rec_d = rec_q;
          o_blk_d = blk_q;
          o_cnt_d = CNT_W'(cnt_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      max_q <= '0;
      ret_q <= RET_RESET;
      cur_q <= '0;
      cur_v_q <= 1'b0;
      day_q <= '0;
      bytes_q <= '0;
      blk_q <= 1'b0;
      hint_q <= '0;
      bad_q <= '0;
      pend_q <= 1'b0;
      left_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cur_q <= cur_d;
      cur_v_q <= cur_v_d;
      day_q <= day_d;
      bytes_q <= bytes_d;
      blk_q <= blk_d;
      hint_q <= hint_d;
      bad_q <= bad_d;
      pend_q <= pend_d;
      left_q <= left_d;
      out_v_q <= out_v_d;
      if (psel && penable && pwrite) begin
        if (reg_e'(paddr[2]) == REG_RETENTION) begin
          ret_q <= pwdata[RET_W-1:0];
        end else begin
          max_q <= pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    idx_q <= idx_d;
    din_q <= din_d;
    need_q <= need_d;
    ld_q <= ld_d;
    scan_a_q <= scan_a_d;
    pend_a_q <= pend_a_d;
    dn_q <= dn_d;
    full_ctx_q <= full_ctx_d;
    force_q <= force_d;
    cnt_q <= cnt_d;
    res_stat_q <= res_stat_d;
    rec_q <= rec_d;
    o_stat_q <= o_stat_d;
    o_cur_q <= o_cur_d;
    o_rec_q <= o_rec_d;
    o_blk_q <= o_blk_d;
    o_cnt_q <= o_cnt_d;
  end

  assign out_valid_o = out_v_q;
  assign status_o = o_stat_q;
  assign current_sector_out_o = o_cur_q;
  assign record_offset_o = o_rec_q;
  assign low_space_flag_o = o_blk_q;
  assign affected_count_o = o_cnt_q;

  a_cur_not_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (cur_q < RES_A)) else $error("current sector is reserved");

  a_bad_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bad_q) <= 32'(BAD_LIST_MAX)) else $error("bad list over cap");

  a_no_reserved_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_CLEAR) |-> (mem_wa != RES_A))
    else $error("write to reserved sector");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("item taken while busy");

  a_no_clear_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pend_q) else $error("scan read during clearing pass");

endmodule

// ===== rtl/lsa_ram.sv =====
module lsa_ram #(
  parameter int Width = 33,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
